// File: rtl/rsw_pkg.sv
// shared types and constants for the reading stability window
`default_nettype none

package rsw_pkg;

	localparam int READING_W = 16;
	localparam int DATA_W    = 14;
	localparam int ERR_W     = 8;
	localparam int CFG_W     = 14;
	localparam int CFG_IDX_W = 2;

	localparam logic [DATA_W-1:0] PH_LOW_RST    = 14'd0;
	localparam logic [DATA_W-1:0] PH_HIGH_RST   = 14'd14000;
	localparam logic [DATA_W-1:0] THRESHOLD_RST = 14'd50;
	localparam logic [ERR_W-1:0]  ERR_LIMIT_RST = 8'd5;
	localparam logic [ERR_W-1:0]  ERR_MAX       = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PH_LOW_LIMIT     = 2'd0,
		REG_PH_HIGH_LIMIT    = 2'd1,
		REG_STABLE_THRESHOLD = 2'd2,
		REG_ERROR_LIMIT      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [READING_W-1:0] reading;
		logic                        read_ok;
	} item_t;

	typedef struct packed {
		logic             accepted;
		logic             stable;
		logic             fault;
		logic [ERR_W-1:0] error_run;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/rsw_window.sv
// circular reading window with running sum and sum of squares
`default_nettype none

module rsw_window import rsw_pkg::*; #(
	parameter int WINDOW_DEPTH = 16,
	localparam int AW  = $clog2(WINDOW_DEPTH),
	localparam int CW  = $clog2(WINDOW_DEPTH + 1),
	localparam int S1W = DATA_W + CW,
	localparam int S2W = 2 * DATA_W + CW
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [DATA_W-1:0] wr_data,
	output logic      [S1W-1:0]    sum1,
	output logic      [S2W-1:0]    sum2,
	output logic                   full
);

	logic [DATA_W-1:0]   mem [WINDOW_DEPTH];
	logic [DATA_W-1:0]   rd_q;
	logic [AW-1:0]       wp_q;
	logic [AW-1:0]       wp_next;
	logic [CW-1:0]       fill_q;
	logic [S1W-1:0]      sum1_q;
	logic [S2W-1:0]      sum2_q;
	logic [DATA_W-1:0]   old_val;
	logic [2*DATA_W-1:0] new_sq;
	logic [2*DATA_W-1:0] old_sq;

	assign full = (fill_q == CW'(WINDOW_DEPTH));

	// entries not yet written count as zero, so only a full window drops a value
	assign old_val = full ? rd_q : '0;
	assign new_sq  = wr_data * wr_data;
	assign old_sq  = old_val * old_val;

	always_comb begin
		wp_next = wp_q;
		if (wr_en) begin
			if (wp_q == AW'(WINDOW_DEPTH - 1)) begin
				wp_next = '0;
			end else begin
				wp_next = wp_q + 1'b1;
			end
		end
	end

	// read runs one slot ahead so the value being replaced is always registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= wr_data;
		end
		rd_q <= mem[wp_next];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			sum1_q <= '0;
			sum2_q <= '0;
		end else if (wr_en) begin
			wp_q   <= wp_next;
			sum1_q <= sum1_q + S1W'(wr_data) - S1W'(old_val);
			sum2_q <= sum2_q + S2W'(new_sq) - S2W'(old_sq);
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign sum1 = sum1_q;
	assign sum2 = sum2_q;

endmodule

`default_nettype wire

// File: rtl/reading_stability_window.sv
// top level: reading validation, error run tracking and window stability test
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------
//  item     | in        | item_valid/item_stall     | item_t: reading, read_ok
//  result   | out       | result_valid/result_stall | result_t: flags, error_run
//  cfg      | in        | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// one item per cycle sustained while result_stall is low; a result leaves the output register
// after its item transaction passes input reg, window update, products and compare in that order
// the window memory has one read port that prefetches the slot to be replaced
// reset clears control, sums and counts; window contents are masked by the fill count
// item_stall rises only when every stage holds an item and the result is stalled

`default_nettype none

module reading_stability_window import rsw_pkg::*; #(
	parameter int WINDOW_DEPTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire item_t                item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_t                   result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int CW   = $clog2(WINDOW_DEPTH + 1);
	localparam int S1W  = DATA_W + CW;
	localparam int S2W  = 2 * DATA_W + CW;
	localparam int CMPW = 2 * (DATA_W + CW);
	localparam int NN   = WINDOW_DEPTH * WINDOW_DEPTH;

	// configuration
	logic [DATA_W-1:0]   ph_low_q;
	logic [DATA_W-1:0]   ph_high_q;
	logic [DATA_W-1:0]   threshold_q;
	logic [ERR_W-1:0]    err_limit_q;
	logic [2*DATA_W-1:0] tsq_q;
	logic [CMPW-1:0]     thr_q;

	// pipeline
	logic             s1_valid_q;
	item_t            item_s1;
	logic             s2_valid_q;
	logic             acc_s2;
	logic             fault_s2;
	logic [ERR_W-1:0] err_s2;
	logic             s3_valid_q;
	logic             acc_s3;
	logic             fault_s3;
	logic             full_s3;
	logic [ERR_W-1:0] err_s3;
	logic [CMPW-1:0]  ns2_s3;
	logic [CMPW-1:0]  s1sq_s3;
	logic             result_valid_q;
	result_t          result_q;

	logic [ERR_W-1:0] err_q;
	logic [ERR_W-1:0] err_next;
	logic             acc_s1;
	logic             out_free;
	logic             s3_free;
	logic             s2_free;
	logic             s1_free;
	logic             s1_move;
	logic             commit;

	logic [S1W-1:0]   win_sum1;
	logic [S2W-1:0]   win_sum2;
	logic             win_full;
	logic [CMPW-1:0]  ns2;
	logic [CMPW-1:0]  s1sq;
	logic             stable_now;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_low_q    <= PH_LOW_RST;
			ph_high_q   <= PH_HIGH_RST;
			threshold_q <= THRESHOLD_RST;
			err_limit_q <= ERR_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PH_LOW_LIMIT:     ph_low_q    <= cfg_data[DATA_W-1:0];
				REG_PH_HIGH_LIMIT:    ph_high_q   <= cfg_data[DATA_W-1:0];
				REG_STABLE_THRESHOLD: threshold_q <= cfg_data[DATA_W-1:0];
				REG_ERROR_LIMIT:      err_limit_q <= cfg_data[ERR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// N^2 * T^2 is rebuilt after a threshold write, T^2 into tsq_q and then times N^2 into thr_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsq_q <= '0;
			thr_q <= '0;
		end else begin
			tsq_q <= threshold_q * threshold_q;
			thr_q <= tsq_q * (2*CW)'(NN);
		end
	end

	// stage flow
	assign out_free   = !result_valid_q || !result_stall;
	assign s3_free    = !s3_valid_q || out_free;
	assign s2_free    = !s2_valid_q || s3_free;
	assign s1_free    = !s1_valid_q || s2_free;
	assign item_stall = !s1_free;
	assign s1_move    = s1_valid_q && s2_free;

	// negative readings fail on the sign bit
	assign acc_s1 = item_s1.read_ok && !item_s1.reading[READING_W-1]
		&& (item_s1.reading[READING_W-2:0] >= {1'b0, ph_low_q})
		&& (item_s1.reading[READING_W-2:0] <= {1'b0, ph_high_q});
	assign commit = s1_move && acc_s1;

	always_comb begin
		if (acc_s1) begin
			err_next = '0;
		end else if (err_q == ERR_MAX) begin
			err_next = err_q;
		end else begin
			err_next = err_q + 1'b1;
		end
	end

	rsw_window #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (commit),
		.wr_data(item_s1.reading[DATA_W-1:0]),
		.sum1   (win_sum1),
		.sum2   (win_sum2),
		.full   (win_full)
	);

	assign ns2  = win_sum2 * CW'(WINDOW_DEPTH);
	assign s1sq = win_sum1 * win_sum1;

	// N*S2 - S1^2 is never negative
	assign stable_now = full_s3 && ((ns2_s3 - s1sq_s3) < thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q     <= 1'b0;
			s2_valid_q     <= 1'b0;
			s3_valid_q     <= 1'b0;
			result_valid_q <= 1'b0;
			err_q          <= '0;
		end else begin
			if (s1_free) begin
				s1_valid_q <= item_valid;
			end
			if (s2_free) begin
				s2_valid_q <= s1_valid_q;
			end
			if (s3_free) begin
				s3_valid_q <= s2_valid_q;
			end
			if (out_free) begin
				result_valid_q <= s3_valid_q;
			end
			if (s1_move) begin
				err_q <= err_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && s1_free) begin
			item_s1 <= item;
		end
		if (s1_move) begin
			acc_s2   <= acc_s1;
			err_s2   <= err_next;
			fault_s2 <= (err_next > err_limit_q);
		end
		if (s2_valid_q && s3_free) begin
			acc_s3   <= acc_s2;
			err_s3   <= err_s2;
			fault_s3 <= fault_s2;
			full_s3  <= win_full;
			ns2_s3   <= ns2;
			s1sq_s3  <= s1sq;
		end
		if (s3_valid_q && out_free) begin
			result_q.accepted  <= acc_s3;
			result_q.stable    <= stable_now;
			result_q.fault     <= fault_s3;
			result_q.error_run <= err_s3;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_accept_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.accepted) |-> (result.error_run == '0))
		else $error("accepted result with nonzero error run");

	a_fault_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.fault) |-> (result.error_run != '0))
		else $error("fault raised with empty error run");

	a_stable_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		!win_full |-> !(result_valid && result.stable))
		else $error("stable reported before window filled");

	a_empty_input_stage_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> !item_stall)
		else $error("input stalled with empty input register");

endmodule

`default_nettype wire

// File: bench/tb_reading_stability_window.sv
// self-checking testbench for the reading stability window
`default_nettype none

module tb_reading_stability_window;
	import rsw_pkg::*;

	localparam int DEPTH      = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	item_t                item;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// tells the sender and receiver to skip their random waits
	bit calm;
	// asks the receiver for one long hold-off
	bit hold_req;
	int idle_cycles;

	reading_stability_window #(.WINDOW_DEPTH(DEPTH)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	class stability_scoreboard;
		logic [DATA_W-1:0] low_lim;
		logic [DATA_W-1:0] high_lim;
		logic [DATA_W-1:0] dev_thr;
		logic [ERR_W-1:0]  err_lim;
		logic [DATA_W-1:0] slots [DEPTH];
		int                wr_pos;
		int                fill;
		logic [ERR_W-1:0]  err_run;
		result_t           expected_q [$];
		int                errors;

		function new();
			low_lim  = PH_LOW_RST;
			high_lim = PH_HIGH_RST;
			dev_thr  = THRESHOLD_RST;
			err_lim  = ERR_LIMIT_RST;
			foreach (slots[i])
				slots[i] = '0;
			wr_pos  = 0;
			fill    = 0;
			err_run = '0;
			errors  = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_PH_LOW_LIMIT:     low_lim  = val[DATA_W-1:0];
				REG_PH_HIGH_LIMIT:    high_lim = val[DATA_W-1:0];
				REG_STABLE_THRESHOLD: dev_thr  = val[DATA_W-1:0];
				REG_ERROR_LIMIT:      err_lim  = val[ERR_W-1:0];
				default: ;
			endcase
		endfunction

		// N*sum(x^2) - sum(x)^2 < N^2*T^2, all in exact integers
		function bit window_stable();
			longint unsigned s1;
			longint unsigned s2;
			longint unsigned n;
			longint unsigned t;
			s1 = 0;
			s2 = 0;
			n  = DEPTH;
			t  = dev_thr;
			if (fill < DEPTH)
				return 1'b0;
			foreach (slots[i]) begin
				s1 += slots[i];
				s2 += longint'(slots[i]) * longint'(slots[i]);
			end
			return (n * s2 - s1 * s1) < (n * n * t * t);
		endfunction

		function void note_item(item_t it);
			int      value;
			int      lo;
			int      hi;
			bit      ok;
			result_t exp_r;
			value = it.reading;
			lo    = int'(low_lim);
			hi    = int'(high_lim);
			ok    = (it.read_ok === 1'b1) && value >= lo && value <= hi;
			if (ok) begin
				err_run       = '0;
				slots[wr_pos] = value[DATA_W-1:0];
				wr_pos        = (wr_pos + 1) % DEPTH;
				if (fill < DEPTH)
					fill++;
			end else if (err_run != ERR_MAX) begin
				err_run++;
			end
			exp_r.accepted  = ok;
			exp_r.stable    = window_stable();
			exp_r.fault     = err_run > err_lim;
			exp_r.error_run = err_run;
			expected_q.push_back(exp_r);
		endfunction

		function void check_result(result_t r);
			result_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: acc=%0b stb=%0b flt=%0b run=%0d",
					$time, r.accepted, r.stable, r.fault, r.error_run);
				return;
			end
			e = expected_q.pop_front();
			if (r.accepted !== e.accepted || r.stable !== e.stable ||
					r.fault !== e.fault || r.error_run !== e.error_run) begin
				errors++;
				$display("%0t: exp a=%0b s=%0b f=%0b r=%0d got a=%0b s=%0b f=%0b r=%0d",
					$time, e.accepted, e.stable, e.fault, e.error_run,
					r.accepted, r.stable, r.fault, r.error_run);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	stability_scoreboard sb;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// transaction monitor on the item and result channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_result(result);
			if (item_valid && !item_stall)
				sb.note_item(item);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("reading_stability_window: mismatch");
				$finish;
			end
		end
	end

	// receiver: random stall before each result, one long hold-off on request
	initial begin
		int wait_cycles;
		bit held;
		result_stall = 1'b1;
		held         = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			wait_cycles = calm ? 0 : $urandom_range(0, 7);
			if (hold_req && !held) begin
				held        = 1'b1;
				wait_cycles = HOLD_CYCLES;
			end
			if (wait_cycles != 0) begin
				result_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_item(input item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!(item_valid && !item_stall));
		@(negedge clk);
	endtask

	task automatic stop_items();
		item_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	// only between phases, once every result has come back
	task automatic configure(input int lo, input int hi, input int thr, input int lim);
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
		write_reg(REG_PH_LOW_LIMIT, lo[CFG_W-1:0]);
		write_reg(REG_PH_HIGH_LIMIT, hi[CFG_W-1:0]);
		write_reg(REG_STABLE_THRESHOLD, thr[CFG_W-1:0]);
		write_reg(REG_ERROR_LIMIT, lim[CFG_W-1:0]);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic item_t make_item(input int value, input bit ok);
		item_t it;
		it.reading = value[READING_W-1:0];
		it.read_ok = ok;
		return it;
	endfunction

	// mostly clustered readings, a little full-range noise and some failed reads
	function automatic item_t random_item(input int center, input int spread);
		int value;
		value = center + int'($urandom_range(0, spread)) - spread / 2;
		if ($urandom_range(0, 11) == 0)
			value = $urandom_range(0, 65535);
		return make_item(value, $urandom_range(0, 9) != 0);
	endfunction

	initial begin
		int lo;
		int hi;
		int thr;
		int lim;
		int center;
		int spread;
		int count;
		sb          = new();
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item        = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_PH_LOW_LIMIT;
		cfg_data    = '0;
		calm        = 1'b0;
		hold_req    = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// range edges, negative and overlarge readings, failed reads
		send_item(make_item(0, 1'b1));
		send_item(make_item(14000, 1'b1));
		send_item(make_item(14001, 1'b1));
		send_item(make_item(-32768, 1'b1));
		send_item(make_item(32767, 1'b1));
		send_item(make_item(-1, 1'b1));
		repeat (3) send_item(make_item(7000, 1'b0));
		// fill the window with a tight cluster so it turns stable
		for (int i = 0; i < DEPTH; i++)
			send_item(make_item(7000 + i % 3, 1'b1));
		stop_items();

		for (int phase = 0; phase < 11; phase++) begin
			case (phase)
				0: begin lo = 0;     hi = 14000; thr = 50;    lim = 5;   end
				1: begin lo = 0;     hi = 16383; thr = 16383; lim = 0;   end
				2: begin lo = 9000;  hi = 3000;  thr = 50;    lim = 5;   end
				3: begin lo = 16383; hi = 16383; thr = 0;     lim = 255; end
				4: begin lo = 3000;  hi = 9000;  thr = 0;     lim = 3;   end
				5: begin lo = 6000;  hi = 8000;  thr = 200;   lim = 255; end
				default: begin
					lo  = $urandom_range(0, 10000);
					hi  = $urandom_range(lo, 16383);
					thr = $urandom_range(0, 600);
					lim = $urandom_range(0, 12);
				end
			endcase
			configure(lo, hi, thr, lim);
			calm = (phase == 0 || phase == 5);
			if (lo <= hi)
				center = $urandom_range(lo, hi);
			else
				center = $urandom_range(0, 14000);
			// long run of rejects to saturate the error count
			if (phase == 3)
				center = 12000;
			count  = (phase == 3) ? 300 : 145;
			spread = 0;
			if (phase == 0)
				hold_req = 1'b1;
			for (int n = 0; n < count; n++) begin
				if (n % 32 == 0) begin
					case ($urandom_range(0, 4))
						0: spread = 0;
						1: spread = thr;
						2: spread = 3 * thr;
						3: spread = 6 * thr;
						default: spread = 2000;
					endcase
					if (phase == 3)
						spread = 4000;
				end
				send_item(random_item(center, spread));
			end
			stop_items();
		end

		while (sb.pending() != 0)
			@(negedge clk);
		repeat (12) @(posedge clk);
		if (sb.errors == 0)
			$display("reading_stability_window: match");
		else
			$display("reading_stability_window: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
